### rtl/mpq_pkg.sv
package mpq_pkg;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_VIEW,
    ST_FRONT,
    ST_RESULT
  } state_e;

  localparam int unsigned CfgWidth = 4;

endpackage

### rtl/mpq_top_sel.sv
module mpq_top_sel #(
  parameter int unsigned LEVEL_COUNT = 8,
  parameter int unsigned LW          = 3
) (
  input  logic [LEVEL_COUNT-1:0]      occ_i,
  input  logic [mpq_pkg::CfgWidth-1:0] levels_in_use_i,
  output logic [LW-1:0]               top_o,
  output logic                        empty_o
);

  logic [LEVEL_COUNT-1:0] en;

  // Level zero is always in use; counts above LEVEL_COUNT clamp by construction.
  always_comb begin
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      en[l] = (l == 0) || (7'(l) < {3'b000, levels_in_use_i});
    end
  end

  always_comb begin
    top_o   = '0;
    empty_o = 1'b1;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if (occ_i[l] && en[l]) begin
        top_o   = LW'(l);
        empty_o = 1'b0;
      end
    end
  end

endmodule

### rtl/multilevel_priority_queue.sv
// Strict-priority queue, one bounded FIFO per level, all items held in one
// synchronous item memory and the head/tail pointers in a small pointer
// memory. busy_o is high from the cycle after start_i is taken until done_o,
// and done_o pulses in the last busy cycle, so a new item can start in the
// cycle after done_o. The sequence follows the chain of dependent registered
// memory reads: pointer, then item for a remove, then pointer and item again
// for the front of the new top level. done_o is a single-cycle pulse with all
// result fields valid in that cycle; the receiver cannot stall, so capture
// them then. Write configuration (cfg_we_i) only while busy_o is low.
module multilevel_priority_queue #(
  parameter int unsigned LEVEL_COUNT = 8,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned ITEM_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [31:0] item_data_i,
  input  logic [2:0]  priority_req_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [31:0] removed_data_o,
  output logic        removed_valid_o,
  output logic [1:0]  status_o,
  output logic        queue_empty_o,
  output logic [2:0]  top_level_o,
  output logic [31:0] front_data_o
);

  localparam int unsigned LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int unsigned PW = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned AW = $clog2(LEVEL_COUNT * LEVEL_DEPTH);
  localparam int unsigned SW = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lv,
                                              input logic [PW-1:0] p);
    slot_addr = AW'(lv) * AW'(LEVEL_DEPTH) + AW'(p);
  endfunction

  mpq_pkg::state_e  state_q, state_d;
  mpq_pkg::cmd_e    cmd_q;
  mpq_pkg::status_e status_q, status_d;
  logic [mpq_pkg::CfgWidth-1:0] cfg_q;
  logic [CW-1:0]    cnt_q [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0] occ;
  logic [LEVEL_COUNT-1:0] ptr_vld_q;
  logic [LW-1:0]    lvl_q, lvl_d;
  logic [LW-1:0]    top_q, sel_top;
  logic             empty_q, sel_empty;
  logic [SW-1:0]    data_q;
  logic [31:0]      removed_q;
  logic             removed_valid_q;

  // Pointer memory: {head, tail} per level.
  logic [2*PW-1:0]  ptr_mem [LEVEL_COUNT];
  logic [2*PW-1:0]  ptr_rd_q, ptr_wdata;
  logic [LW-1:0]    ptr_raddr;
  logic             ptr_we;
  logic [PW-1:0]    rd_head, rd_tail;

  // Item memory.
  logic [SW-1:0]    item_mem [LEVEL_COUNT * LEVEL_DEPTH];
  logic [SW-1:0]    item_rd_q;
  logic [AW-1:0]    item_raddr, item_waddr;
  logic             item_we;

  logic             accept, prio_ok, lvl_full, do_op;

  assign accept  = start_i && (state_q == mpq_pkg::ST_IDLE);
  assign rd_head = ptr_rd_q[2*PW-1:PW];
  assign rd_tail = ptr_rd_q[PW-1:0];

  always_comb begin
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      occ[l] = (cnt_q[l] != '0);
    end
  end

  mpq_top_sel #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .LW         (LW)
  ) u_top_sel (
    .occ_i          (occ),
    .levels_in_use_i(cfg_q),
    .top_o          (sel_top),
    .empty_o        (sel_empty)
  );

  assign prio_ok = ({4'b0000, priority_req_i} < 7'(LEVEL_COUNT)) &&
                   ((priority_req_i == 3'd0) || ({1'b0, priority_req_i} < cfg_q));
  assign lvl_full = prio_ok && (cnt_q[LW'(priority_req_i)] == CW'(LEVEL_DEPTH));

  always_comb begin
    if (mpq_pkg::cmd_e'(cmd_i) == mpq_pkg::CMD_ADD) begin
      lvl_d = LW'(priority_req_i);
      if (!prio_ok) begin
        status_d = mpq_pkg::STATUS_RANGE;
      end else if (lvl_full) begin
        status_d = mpq_pkg::STATUS_FULL;
      end else begin
        status_d = mpq_pkg::STATUS_OK;
      end
    end else begin
      lvl_d    = sel_top;
      status_d = sel_empty ? mpq_pkg::STATUS_EMPTY : mpq_pkg::STATUS_OK;
    end
  end

  assign do_op = (state_q == mpq_pkg::ST_UPDATE) && (status_q == mpq_pkg::STATUS_OK);

  // Memory addressing and write data.
  always_comb begin
    ptr_raddr  = (state_q == mpq_pkg::ST_IDLE) ? lvl_d : sel_top;
    item_raddr = slot_addr((state_q == mpq_pkg::ST_UPDATE) ? lvl_q : top_q, rd_head);
    item_waddr = slot_addr(lvl_q, rd_tail);
    item_we    = do_op && (cmd_q == mpq_pkg::CMD_ADD);
    ptr_we     = do_op;
    if (cmd_q == mpq_pkg::CMD_ADD) begin
      ptr_wdata = {rd_head, next_slot(rd_tail)};
    end else begin
      ptr_wdata = {next_slot(rd_head), rd_tail};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpq_pkg::ST_IDLE:   if (start_i) state_d = mpq_pkg::ST_UPDATE;
      mpq_pkg::ST_UPDATE: state_d = mpq_pkg::ST_VIEW;
      mpq_pkg::ST_VIEW:   state_d = mpq_pkg::ST_FRONT;
      mpq_pkg::ST_FRONT:  state_d = mpq_pkg::ST_RESULT;
      mpq_pkg::ST_RESULT: state_d = mpq_pkg::ST_IDLE;
      default:            state_d = mpq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mpq_pkg::ST_IDLE;
      cfg_q     <= 4'd8;
      ptr_vld_q <= '0;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        cnt_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (ptr_we) begin
        ptr_vld_q[lvl_q] <= 1'b1;
      end
      if (do_op) begin
        if (cmd_q == mpq_pkg::CMD_ADD) begin
          cnt_q[lvl_q] <= cnt_q[lvl_q] + 1'b1;
        end else begin
          cnt_q[lvl_q] <= cnt_q[lvl_q] - 1'b1;
        end
      end
    end
  end

  // Item fields and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= mpq_pkg::cmd_e'(cmd_i);
      data_q   <= SW'(item_data_i);
      lvl_q    <= lvl_d;
      status_q <= status_d;
    end
    if (state_q == mpq_pkg::ST_VIEW) begin
      removed_valid_q <= (cmd_q == mpq_pkg::CMD_REMOVE) && (status_q == mpq_pkg::STATUS_OK);
      if ((cmd_q == mpq_pkg::CMD_REMOVE) && (status_q == mpq_pkg::STATUS_OK)) begin
        removed_q <= 32'(item_rd_q);
      end else begin
        removed_q <= '0;
      end
      top_q   <= sel_top;
      empty_q <= sel_empty;
    end
  end

  // Pointer memory; an entry never written reads as zero.
  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[lvl_q] <= ptr_wdata;
    end
    ptr_rd_q <= ptr_vld_q[ptr_raddr] ? ptr_mem[ptr_raddr] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (item_we) begin
      item_mem[item_waddr] <= data_q;
    end
    item_rd_q <= item_mem[item_raddr];
  end

  assign busy_o          = (state_q != mpq_pkg::ST_IDLE);
  assign done_o          = (state_q == mpq_pkg::ST_RESULT);
  assign removed_data_o  = removed_q;
  assign removed_valid_o = removed_valid_q;
  assign status_o        = status_q;
  assign queue_empty_o   = empty_q;
  assign top_level_o     = empty_q ? 3'd0 : 3'(top_q);
  assign front_data_o    = empty_q ? 32'd0 : 32'(item_rd_q);

endmodule
